/* hdl/dpcu_pkg.sv */
// ----------------------------------------------------------------------------
// dpcu_pkg
// Shared types and constants of the DDR performance counter unit: command
// codes, register word offsets and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
package dpcu_pkg;

  // default sizing
  localparam int NUM_COUNTERS_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int CYCLE_WIDTH_DEF  = 56;

  // transaction command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // register word offsets (byte offset >> 2)
  localparam logic [9:0] W_CTRL    = 10'(12'hC00 >> 2);
  localparam logic [9:0] W_STATE   = 10'(12'hC04 >> 2);
  localparam logic [9:0] W_TSEL    = 10'(12'hC08 >> 2);
  localparam logic [9:0] W_PRELOAD = 10'(12'hC0C >> 2);
  localparam logic [9:0] W_CYC_HI  = 10'(12'hC10 >> 2);
  localparam logic [9:0] W_CYC_LO  = 10'(12'hC14 >> 2);
  localparam logic [9:0] W_SEL0    = 10'(12'hC68 >> 2);
  localparam logic [9:0] W_CNT0    = 10'(12'hC78 >> 2);
  localparam logic [9:0] W_OV_SET  = 10'(12'hCB8 >> 2);
  localparam logic [9:0] W_OV_CLRE = 10'(12'hCBC >> 2);
  localparam logic [9:0] W_OV_EN   = 10'(12'hCC0 >> 2);
  localparam logic [9:0] W_OV_CLR  = 10'(12'hCC4 >> 2);
  localparam logic [9:0] W_OV_STAT = 10'(12'hCC8 >> 2);

  // number of select words and counter slots in the map
  localparam logic [9:0] SEL_WORDS = 10'd4;
  localparam logic [9:0] CNT_SLOTS = 10'd16;

  // control register bits
  localparam int CTRL_START = 0;
  localparam int CTRL_STOP  = 1;
  localparam int CTRL_CLEAR = 2;

  // test select value that targets counter 0 for preload
  localparam int PRELOAD_BASE = 19;

  // lowest bit of the per-counter fields in the overflow registers
  localparam int OV_LSB = 8;

  // output buffer state
  typedef enum logic {
    OUT_EMPTY = 1'b0,
    OUT_FULL  = 1'b1
  } out_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic tick;
    logic rd;
    logic wr;
  } dp_cmd_t;

endpackage

/* hdl/dpcu_if.sv */
// ----------------------------------------------------------------------------
// dpcu_if
// Valid/ready channels of the DDR performance counter unit: the request
// channel with command and register payload, and the response channel.
// ----------------------------------------------------------------------------
interface dpcu_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] addr;
  logic [31:0] wdata;
  logic [63:0] events;

  modport source (output valid, cmd, addr, wdata, events, input ready);
  modport sink   (input valid, cmd, addr, wdata, events, output ready);
endinterface

interface dpcu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        irq;

  modport source (output valid, rdata, irq, input ready);
  modport sink   (input valid, rdata, irq, output ready);
endinterface

/* hdl/dpcu_ctrl.sv */
// ----------------------------------------------------------------------------
// dpcu_ctrl
// Handshake controller: tracks the response buffer, decides when a request
// transaction is taken and decodes its command for the datapath.
// ----------------------------------------------------------------------------
module dpcu_ctrl import dpcu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_cmd,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output dp_cmd_t    dp_cmd
);

  out_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OUT_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      OUT_EMPTY: begin
        if (req_valid) state_next = OUT_FULL;
      end
      OUT_FULL: begin
        if (rsp_ready && !req_valid) state_next = OUT_EMPTY;
      end
      default: state_next = OUT_EMPTY;
    endcase
  end

  // outputs and command decode
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      OUT_EMPTY: req_ready = 1'b1;
      OUT_FULL: begin
        req_ready = rsp_ready;
        rsp_valid = 1'b1;
      end
      default: req_ready = 1'b0;
    endcase
    dp_cmd.accept = req_valid && req_ready;
    dp_cmd.tick   = 1'b0;
    dp_cmd.rd     = 1'b0;
    dp_cmd.wr     = 1'b0;
    case (req_cmd)
      CMD_TICK:  dp_cmd.tick = dp_cmd.accept;
      CMD_READ:  dp_cmd.rd   = dp_cmd.accept;
      CMD_WRITE: dp_cmd.wr   = dp_cmd.accept;
      default:   dp_cmd.tick = 1'b0;
    endcase
  end

endmodule

/* hdl/dpcu_dp.sv */
// ----------------------------------------------------------------------------
// dpcu_dp
// Datapath: event counters, cycle counter, select and overflow registers,
// register read mux and the response output register.
// ----------------------------------------------------------------------------
module dpcu_dp import dpcu_pkg::*; #(
  parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int CYCLE_WIDTH  = CYCLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     dp_cmd,
  input  logic [11:0] req_addr,
  input  logic [31:0] req_wdata,
  input  logic [63:0] req_events,
  output logic [31:0] rsp_rdata,
  output logic        rsp_irq
);

  // architectural state
  logic                    running;
  logic [CYCLE_WIDTH-1:0]  cycle_count;
  logic [COUNT_WIDTH-1:0]  cnt [NUM_COUNTERS];
  logic [7:0]              sel [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] ov_en;
  logic [NUM_COUNTERS-1:0] ov_stat;
  logic [5:0]              tsel;

  // next values
  logic                    running_next;
  logic [CYCLE_WIDTH-1:0]  cycle_count_next;
  logic [COUNT_WIDTH-1:0]  cnt_next [NUM_COUNTERS];
  logic [7:0]              sel_next [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] ov_en_next;
  logic [NUM_COUNTERS-1:0] ov_stat_next;
  logic [5:0]              tsel_next;
  logic [31:0]             rdata_next;

  // address decode
  logic [9:0]              word;
  logic [9:0]              sel_off;
  logic [9:0]              cnt_off;
  logic                    sel_hit;
  logic                    cnt_hit;
  logic                    ctrl_wr;
  logic                    tick_run;
  logic [NUM_COUNTERS-1:0] wbits;
  logic [63:0]             cyc64;

  always_comb begin
    word     = req_addr[11:2];
    sel_off  = word - W_SEL0;
    cnt_off  = word - W_CNT0;
    sel_hit  = sel_off < SEL_WORDS;
    cnt_hit  = cnt_off < CNT_SLOTS;
    ctrl_wr  = dp_cmd.wr && (word == W_CTRL);
    tick_run = dp_cmd.tick && running;
    wbits    = req_wdata[OV_LSB +: NUM_COUNTERS];
    cyc64    = 64'(cycle_count);
  end

  // control, cycle counter and single registers
  always_comb begin
    running_next     = running;
    cycle_count_next = cycle_count;
    tsel_next        = tsel;
    ov_en_next       = ov_en;
    if (tick_run) cycle_count_next = cycle_count + 1'b1;
    if (ctrl_wr) begin
      if (req_wdata[CTRL_CLEAR]) cycle_count_next = '0;
      if (req_wdata[CTRL_START]) running_next = 1'b1;
      if (req_wdata[CTRL_STOP])  running_next = 1'b0;
    end
    if (dp_cmd.wr && word == W_TSEL)    tsel_next  = req_wdata[5:0];
    if (dp_cmd.wr && word == W_OV_SET)  ov_en_next = ov_en | wbits;
    if (dp_cmd.wr && word == W_OV_CLRE) ov_en_next = ov_en & ~wbits;
  end

  // per-counter lanes: select, increment, preload, overflow
  always_comb begin
    logic [COUNT_WIDTH-1:0] inc;
    ov_stat_next = ov_stat;
    if (dp_cmd.wr && word == W_OV_CLR) ov_stat_next = ov_stat & ~wbits;
    for (int n = 0; n < NUM_COUNTERS; n++) begin
      inc         = cnt[n] + 1'b1;
      cnt_next[n] = cnt[n];
      sel_next[n] = sel[n];
      if (tick_run && sel[n][7] && req_events[sel[n][5:0]]) begin
        cnt_next[n] = inc;
        if (inc == '0) ov_stat_next[n] = 1'b1;
      end
      if (ctrl_wr && req_wdata[CTRL_CLEAR]) cnt_next[n] = '0;
      if (dp_cmd.wr && word == W_PRELOAD && tsel == 6'(PRELOAD_BASE + n))
        cnt_next[n] = req_wdata[COUNT_WIDTH-1:0];
      if (dp_cmd.wr && sel_hit && sel_off[1:0] == 2'(n >> 2))
        sel_next[n] = req_wdata[8*(n%4) +: 8];
    end
  end

  // register read mux
  always_comb begin
    rdata_next = '0;
    if (dp_cmd.rd) begin
      if (word == W_STATE)   rdata_next = 32'(running);
      if (word == W_TSEL)    rdata_next = 32'(tsel);
      if (word == W_CYC_HI)  rdata_next = cyc64[63:32];
      if (word == W_CYC_LO)  rdata_next = cyc64[31:0];
      if (word == W_OV_EN)   rdata_next = 32'(ov_en) << OV_LSB;
      if (word == W_OV_STAT) rdata_next = 32'(ov_stat) << OV_LSB;
      for (int n = 0; n < NUM_COUNTERS; n++) begin
        if (sel_hit && sel_off[1:0] == 2'(n >> 2))
          rdata_next[8*(n%4) +: 8] = sel[n];
        if (cnt_hit && cnt_off[3:0] == 4'(n))
          rdata_next = 32'(cnt[n]);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      cycle_count <= '0;
      ov_en       <= '0;
      ov_stat     <= '0;
      tsel        <= '0;
      for (int n = 0; n < NUM_COUNTERS; n++) begin
        cnt[n] <= '0;
        sel[n] <= '0;
      end
    end else if (dp_cmd.accept) begin
      running     <= running_next;
      cycle_count <= cycle_count_next;
      ov_en       <= ov_en_next;
      ov_stat     <= ov_stat_next;
      tsel        <= tsel_next;
      for (int n = 0; n < NUM_COUNTERS; n++) begin
        cnt[n] <= cnt_next[n];
        sel[n] <= sel_next[n];
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (dp_cmd.accept) begin
      rsp_rdata <= rdata_next;
      rsp_irq   <= |(ov_stat_next & ov_en_next);
    end
  end

endmodule

/* hdl/ddr_perf_counter_unit_core.sv */
// ----------------------------------------------------------------------------
// ddr_perf_counter_unit_core
// DDR controller performance monitor: event counters, cycle counter and a
// register map reached through a request/response channel pair.
// ----------------------------------------------------------------------------
// Each request transaction (tick, register read or register write) yields
// exactly one response holding rdata and irq, registered in the cycle after the
// request is taken. The response register lets a new request in on the same
// cycle the previous response leaves, so one transaction per cycle is
// sustained while the response side keeps ready high; the only limit is that
// single output register. All counters update in parallel in the accepting
// cycle; there is no clearing pass after reset.
module ddr_perf_counter_unit_core import dpcu_pkg::*; #(
  parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int CYCLE_WIDTH  = CYCLE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  dpcu_req_if.sink   req,
  dpcu_rsp_if.source rsp
);

  dp_cmd_t dp_cmd;

  // handshake controller
  dpcu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  // counters and register file
  dpcu_dp #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .CYCLE_WIDTH  (CYCLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .req_addr   (req.addr),
    .req_wdata  (req.wdata),
    .req_events (req.events),
    .rsp_rdata  (rsp.rdata),
    .rsp_irq    (rsp.irq)
  );

endmodule
